@@ src/otrb_pkg.sv @@
`default_nettype none

package otrb_pkg;

	localparam int BYTE_W     = 8;
	localparam int CFG_W      = 13;
	localparam int CNT_W      = 7;
	localparam int USED_W     = 13;
	localparam int IN_DATA_W  = 16;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 24;
	localparam int OUT_USER_W = 2;

	localparam logic [1:0] OPC_APPEND = 2'd0;
	localparam logic [1:0] OPC_READ   = 2'd1;
	localparam logic [1:0] OPC_QUERY  = 2'd2;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_USED = 1'b1;

	typedef enum logic [1:0] {
		OP_APPEND,
		OP_READ,
		OP_QUERY
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t           op;
		logic [BYTE_W-1:0] data;
		logic [CNT_W-1:0]  count;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_req_t;

endpackage

`default_nettype wire

@@ src/otrb_front.sv @@
`default_nettype none

module otrb_front import otrb_pkg::*; #(
	parameter int MAX_READ = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [IN_DATA_W-1:0] s_tdata,   // log_byte[7:0], read_count[14:8], pad
	input  wire logic [IN_USER_W-1:0] s_tuser,   // opcode[1:0]
	output cmd_req_t                  q_req,
	input  wire logic                 q_pop
);

	cmd_t             dec_cmd;
	logic             dec_keep;
	logic [CNT_W-1:0] rc;

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign rc = s_tdata[BYTE_W +: CNT_W];

	always_comb begin
		dec_cmd.data  = s_tdata[BYTE_W-1:0];
		dec_cmd.count = (rc > CNT_W'(MAX_READ)) ? CNT_W'(MAX_READ) : rc;
		dec_cmd.op    = OP_APPEND;
		dec_keep      = 1'b1;
		unique case (s_tuser)
			OPC_APPEND: dec_cmd.op = OP_APPEND;
			OPC_READ:   dec_cmd.op = OP_READ;
			OPC_QUERY:  dec_cmd.op = OP_QUERY;
			default:    dec_keep   = 1'b0;
		endcase
	end

	assign s_tready = (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready && dec_keep;
	assign pop      = q_pop && (cnt_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= dec_cmd;
		end
	end

	assign q_req.valid = (cnt_q != 2'd0);
	assign q_req.cmd   = fifo_q[rd_ptr_q];

endmodule

`default_nettype wire

@@ src/otrb_back.sv @@
`default_nettype none

module otrb_back import otrb_pkg::*; #(
	parameter int STORE_DEPTH = 4096
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_W-1:0]      cfg_data,
	input  wire cmd_req_t              q_req,
	output logic                       q_pop,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,   // read_byte[7:0], used_count[20:8], pad
	output logic [OUT_USER_W-1:0]      m_tuser,   // kind[0], empty_res[1]
	output logic                       m_tlast
);

	localparam int AW   = $clog2(STORE_DEPTH);
	localparam int CAPW = $clog2(STORE_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EMIT
	} state_t;

	state_t                  state_q;
	logic [CAPW-1:0]         cap_q;
	logic [AW-1:0]           wp_q;
	logic                    wrapped_q;
	logic [AW-1:0]           addr_q;
	logic [CNT_W-1:0]        remain_q;
	logic [BYTE_W-1:0]       rdata_q;
	logic                    m_tvalid_q;
	logic [OUT_DATA_W-1:0]   m_tdata_q;
	logic [OUT_USER_W-1:0]   m_tuser_q;
	logic                    m_tlast_q;

	logic [BYTE_W-1:0]       mem [STORE_DEPTH];

	logic [CAPW-1:0]         cap_new;
	logic [CAPW-1:0]         used;
	logic [CNT_W-1:0]        want;
	logic [31:0]             wp_inc;
	logic                    wp_wrap;
	logic [31:0]             first_idx;
	logic [31:0]             addr_inc;
	logic                    addr_wrap;
	logic                    out_free;
	logic                    out_load;
	logic                    mem_wr;

	assign cfg_ready = 1'b1;

	always_comb begin
		if (cfg_data == '0) begin
			cap_new = CAPW'(1);
		end else if (32'(cfg_data) > 32'(STORE_DEPTH)) begin
			cap_new = CAPW'(STORE_DEPTH);
		end else begin
			cap_new = CAPW'(cfg_data);
		end
	end

	assign used      = wrapped_q ? cap_q : CAPW'(wp_q);
	assign want      = (32'(used) < 32'(q_req.cmd.count)) ? CNT_W'(used) : q_req.cmd.count;
	assign wp_inc    = 32'(wp_q) + 32'd1;
	assign wp_wrap   = (wp_inc >= 32'(cap_q));
	assign first_idx = (32'(wp_q) >= 32'(want)) ? (32'(wp_q) - 32'(want))
		: (32'(wp_q) + 32'(cap_q) - 32'(want));
	assign addr_inc  = 32'(addr_q) + 32'd1;
	assign addr_wrap = (addr_inc >= 32'(cap_q));
	assign out_free  = !m_tvalid_q || m_tready;

	always_comb begin
		q_pop = 1'b0;
		if (state_q == ST_IDLE && q_req.valid) begin
			unique case (q_req.cmd.op)
				OP_APPEND: q_pop = 1'b1;
				OP_READ:   q_pop = (want != '0) || out_free;
				OP_QUERY:  q_pop = out_free;
				default:   q_pop = 1'b1;
			endcase
		end
	end

	always_comb begin
		out_load = 1'b0;
		if (state_q == ST_IDLE) begin
			out_load = q_pop && ((q_req.cmd.op == OP_QUERY)
				|| (q_req.cmd.op == OP_READ && want == '0));
		end else if (state_q == ST_EMIT) begin
			out_load = out_free;
		end
	end

	assign mem_wr = q_pop && (q_req.cmd.op == OP_APPEND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cap_q      <= CAPW'(STORE_DEPTH);
			wp_q       <= '0;
			wrapped_q  <= 1'b0;
			addr_q     <= '0;
			remain_q   <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= '0;
			m_tlast_q  <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_valid) begin
				cap_q     <= cap_new;
				wp_q      <= '0;
				wrapped_q <= 1'b0;
			end else if (mem_wr) begin
				wp_q <= wp_wrap ? '0 : AW'(wp_inc);
				if (wp_wrap) begin
					wrapped_q <= 1'b1;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						unique case (q_req.cmd.op)
							OP_APPEND: ;
							OP_QUERY: begin
								m_tdata_q  <= {(OUT_DATA_W-USED_W-BYTE_W)'(0), USED_W'(used),
									BYTE_W'(0)};
								m_tuser_q  <= {1'b0, KIND_USED};
								m_tlast_q  <= 1'b1;
							end
							OP_READ: begin
								if (want == '0) begin
									m_tdata_q  <= '0;
									m_tuser_q  <= {1'b1, KIND_DATA};
									m_tlast_q  <= 1'b1;
								end else begin
									addr_q   <= AW'(first_idx);
									remain_q <= want;
									state_q  <= ST_FETCH;
								end
							end
							default: ;
						endcase
					end
				end
				ST_FETCH: begin
					addr_q  <= addr_wrap ? '0 : AW'(addr_inc);
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						m_tdata_q  <= {(OUT_DATA_W-BYTE_W)'(0), rdata_q};
						m_tuser_q  <= {1'b0, KIND_DATA};
						m_tlast_q  <= (remain_q == CNT_W'(1));
						remain_q   <= remain_q - CNT_W'(1);
						state_q    <= (remain_q == CNT_W'(1)) ? ST_IDLE : ST_FETCH;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			mem[wp_q] <= q_req.cmd.data;
		end
		if (state_q == ST_FETCH) begin
			rdata_q <= mem[addr_q];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

`default_nettype wire

@@ src/overwrite_trace_ring_buffer.sv @@
// Circular trace store that overwrites its oldest bytes.
// Input stream (s_*): opcode in s_tuser (append, read, query), the byte to
// append and the requested read count in s_tdata. Opcode three is dropped.
// Output stream (m_*): one word per query, one word per byte read back
// (oldest first), or one empty word when a read has nothing to return;
// m_tlast marks the final word of each request.
// Config channel (cfg_*): writes the capacity, clamped to 1..STORE_DEPTH,
// and clears the write pointer and wrapped flag. Write only while idle.
// A two-entry command queue sits between the decoder and the executor.
// Appends retire at one per cycle while the executor is idle. A query is
// answered in the cycle after it leaves the queue. A read handles its bytes
// in turn: each byte is a store read followed by an output register load.
// Reset clears the pointer and wrapped flag and sets capacity to STORE_DEPTH;
// store contents are undefined until written.
// When m_tready is low the executor holds its result in the output register;
// the next read or query then stalls it, the queue fills and s_tready drops.

`default_nettype none

module overwrite_trace_ring_buffer import otrb_pkg::*; #(
	parameter int STORE_DEPTH = 4096,
	parameter int MAX_READ    = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_W-1:0]      cfg_data,    // capacity[12:0]
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,     // log_byte[7:0], read_count[14:8], pad
	input  wire logic [IN_USER_W-1:0]  s_tuser,     // opcode[1:0]
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,     // read_byte[7:0], used_count[20:8], pad
	output logic [OUT_USER_W-1:0]      m_tuser,     // kind[0], empty_res[1]
	output logic                       m_tlast
);

	cmd_req_t q_req;
	logic     q_pop;

	otrb_front #(
		.MAX_READ (MAX_READ)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_req    (q_req),
		.q_pop    (q_pop)
	);

	otrb_back #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.q_req     (q_req),
		.q_pop     (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (m_tlast && m_tuser[0] == KIND_DATA))
		else $error("empty result not a single final word");

	a_query_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0] == KIND_USED) |-> (m_tlast && m_tdata[BYTE_W-1:0] == '0))
		else $error("query result malformed");

	a_stall_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> q_req.valid)
		else $error("input stalled with empty queue");

	a_pop_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_req.valid)
		else $error("queue popped while empty");

endmodule

`default_nettype wire

@@ verif/tb_overwrite_trace_ring_buffer.sv @@
`timescale 1ns / 100ps

module tb_overwrite_trace_ring_buffer;
	import otrb_pkg::*;

	localparam int STORE_DEPTH   = 4096;
	localparam int MAX_READ      = 64;
	localparam int RUN_LIMIT     = 1000000;
	localparam int SETTLE_CYCLES = 16;
	localparam int TAIL_CYCLES   = 200;
	localparam int HOLD_CYCLES   = 300;

	localparam logic [1:0] OPC_IGNORED = 2'd3;

	typedef struct packed {
		logic [1:0]        op;
		logic [BYTE_W-1:0] data;
		logic [CNT_W-1:0]  count;
	} trace_cmd_t;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] rbyte;
		logic [USED_W-1:0] used;
		logic              is_empty;
		logic              is_last;
	} trace_res_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_W-1:0]      cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;  // log_byte[7:0], read_count[14:8], pad
	logic [IN_USER_W-1:0]  s_tuser   = '0;  // opcode[1:0]
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;         // read_byte[7:0], used_count[20:8], pad
	logic [OUT_USER_W-1:0] m_tuser;         // kind[0], empty_res[1]
	logic                  m_tlast;

	overwrite_trace_ring_buffer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// trace store mirror
	logic [BYTE_W-1:0] trace_mem [STORE_DEPTH];
	int                trace_wr_ptr  = 0;
	logic              trace_wrapped = 1'b0;
	int                trace_cap     = STORE_DEPTH;

	trace_cmd_t pending_cmds [$];
	trace_res_t expected_results [$];
	trace_cmd_t next_cmd;

	logic in_fire       = 1'b0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   stall_req     = 0;
	int   stall_seen    = 0;
	int   stall_left    = 0;
	int   error_count   = 0;
	int   words_taken   = 0;
	int   results_checked = 0;
	int   cap_writes    = 0;
	int   cycle_count   = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic trace_res_t make_res(input logic kind, input logic [BYTE_W-1:0] rbyte,
			input int used, input logic is_empty, input logic is_last);
		trace_res_t r;
		r.kind     = kind;
		r.rbyte    = rbyte;
		r.used     = used[USED_W-1:0];
		r.is_empty = is_empty;
		r.is_last  = is_last;
		return r;
	endfunction

	function automatic void set_capacity(input logic [CFG_W-1:0] value);
		if (value == 0) begin
			trace_cap = 1;
		end else if (int'(value) > STORE_DEPTH) begin
			trace_cap = STORE_DEPTH;
		end else begin
			trace_cap = int'(value);
		end
		trace_wr_ptr  = 0;
		trace_wrapped = 1'b0;
	endfunction

	function automatic void predict_word(input trace_cmd_t c);
		int used;
		int n;
		int want;
		int skip;
		int start;
		used = trace_wrapped ? trace_cap : trace_wr_ptr;
		case (c.op)
			OPC_APPEND: begin
				trace_mem[trace_wr_ptr] = c.data;
				trace_wr_ptr++;
				if (trace_wr_ptr >= trace_cap) begin
					trace_wr_ptr  = 0;
					trace_wrapped = 1'b1;
				end
			end
			OPC_QUERY: begin
				expected_results.push_back(make_res(KIND_USED, '0, used, 1'b0, 1'b1));
			end
			OPC_READ: begin
				n    = (int'(c.count) > MAX_READ) ? MAX_READ : int'(c.count);
				want = (used < n) ? used : n;
				if (want == 0) begin
					expected_results.push_back(make_res(KIND_DATA, '0, 0, 1'b1, 1'b1));
				end else begin
					skip  = used - want;
					start = trace_wrapped ? trace_wr_ptr : 0;
					for (int i = 0; i < want; i++) begin
						expected_results.push_back(make_res(KIND_DATA,
							trace_mem[(start + skip + i) % trace_cap], 0, 1'b0, i == want - 1));
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void cmp_field(input string name, input int exp, input int act);
		if (exp != act) begin
			$error("%s: expected %0d, got %0d", name, exp, act);
			error_count++;
		end
	endfunction

	function automatic void check_result(input trace_res_t got);
		trace_res_t want;
		if (expected_results.size() == 0) begin
			$error("unexpected result word: kind %0d byte %0d used %0d empty %0d last %0d",
				got.kind, got.rbyte, got.used, got.is_empty, got.is_last);
			error_count++;
			return;
		end
		want = expected_results.pop_front();
		cmp_field("kind", int'(want.kind), int'(got.kind));
		cmp_field("read_byte", int'(want.rbyte), int'(got.rbyte));
		cmp_field("used_count", int'(want.used), int'(got.used));
		cmp_field("empty_res", int'(want.is_empty), int'(got.is_empty));
		cmp_field("last", int'(want.is_last), int'(got.is_last));
		results_checked++;
	endfunction

	// monitor: sample both streams and the config channel
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				check_result(make_res(m_tuser[0], m_tdata[7:0], int'(m_tdata[20:8]), m_tuser[1],
					m_tlast));
			end
			if (s_tvalid && s_tready) begin
				predict_word({s_tuser, s_tdata[7:0], s_tdata[14:8]});
				words_taken++;
			end
			if (cfg_valid && cfg_ready) begin
				set_capacity(cfg_data);
				cap_writes++;
			end
		end
		in_fire <= arst_n && s_tvalid && s_tready;
	end

	// input driver
	always @(negedge clk) begin
		if (!s_tvalid || in_fire) begin
			if (arst_n && pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_cmd = pending_cmds.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= next_cmd.op;
				s_tdata  <= {1'b0, next_cmd.count, next_cmd.data};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// output backpressure, with a single long hold-off
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (stall_req != stall_seen) begin
			stall_seen = stall_req;
			stall_left = HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$error("timeout after %0d cycles, %0d results outstanding", cycle_count,
			expected_results.size());
		$display("overwrite_trace_ring_buffer test failed");
		$finish;
	end

	function automatic void push_cmd(input logic [1:0] op, input int data, input int count);
		trace_cmd_t c;
		c.op    = op;
		c.data  = data[BYTE_W-1:0];
		c.count = count[CNT_W-1:0];
		pending_cmds.push_back(c);
	endfunction

	// bursts of appends mixed with reads and queries, a little noise
	function automatic void push_random(input int n);
		int made;
		int burst;
		int pick;
		made = 0;
		while (made < n) begin
			pick = $urandom_range(99);
			if (pick < 50) begin
				burst = $urandom_range(8, 1);
				repeat (burst) push_cmd(OPC_APPEND, $urandom_range(255), $urandom_range(127));
				made += burst;
			end else if (pick < 78) begin
				push_cmd(OPC_READ, $urandom_range(255),
					($urandom_range(7) == 0) ? $urandom_range(127, 65) : $urandom_range(MAX_READ));
				made++;
			end else if (pick < 95) begin
				push_cmd(OPC_QUERY, $urandom_range(255), $urandom_range(127));
				made++;
			end else begin
				push_cmd(OPC_IGNORED, $urandom_range(255), $urandom_range(127));
			end
		end
	endfunction

	task automatic wait_drained(input int limit);
		int waited;
		waited = 0;
		do begin
			@(posedge clk);
			waited++;
		end while ((pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0)
			&& waited < limit);
	endtask

	task automatic write_capacity(input int value);
		int target;
		wait_drained(RUN_LIMIT);
		repeat (SETTLE_CYCLES) @(posedge clk);
		target = cap_writes + 1;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value[CFG_W-1:0];
		wait (cap_writes == target);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 29;
		recv_idle_pct = 57;
		// reset capacity, empty store first
		push_cmd(OPC_QUERY, 0, 0);
		push_cmd(OPC_READ, 0, 0);
		push_cmd(OPC_READ, 0, 10);
		push_cmd(OPC_APPEND, 8'h00, 127);
		push_cmd(OPC_APPEND, 8'hFF, 0);
		push_cmd(OPC_APPEND, 8'h5A, 0);
		push_cmd(OPC_APPEND, 8'hA5, 0);
		push_cmd(OPC_QUERY, 8'hFF, 127);
		push_cmd(OPC_READ, 8'hFF, 127);
		push_cmd(OPC_READ, 0, MAX_READ);
		push_cmd(OPC_READ, 0, 2);
		push_cmd(OPC_READ, 0, 1);
		push_cmd(OPC_IGNORED, 8'hFF, 127);
		push_cmd(OPC_QUERY, 0, 0);
		push_cmd(OPC_READ, 0, 0);
		push_cmd(OPC_READ, 0, 100);
		push_cmd(OPC_APPEND, 8'h81, 0);
		push_cmd(OPC_READ, 0, 65);
		wait_drained(RUN_LIMIT);

		write_capacity(0);
		push_random(40);
		write_capacity(7);
		push_random(90);

		wait_drained(RUN_LIMIT);
		send_idle_pct = 57;
		recv_idle_pct = 29;
		write_capacity(1);
		push_random(30);
		write_capacity(65);
		push_random(110);
		write_capacity(2);
		push_random(40);

		wait_drained(RUN_LIMIT);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// oversize capacity clamps to the full store, then a longer run of appends
		write_capacity(8191);
		for (int i = 0; i < 70; i++) begin
			push_cmd(OPC_APPEND, $urandom_range(255), $urandom_range(127));
		end
		push_cmd(OPC_QUERY, 0, 0);
		push_cmd(OPC_READ, 0, MAX_READ);
		push_cmd(OPC_READ, 0, 127);
		push_cmd(OPC_QUERY, 0, 0);
		push_cmd(OPC_READ, 0, 0);

		write_capacity(STORE_DEPTH);
		stall_req++;
		push_random(30);
		wait_drained(RUN_LIMIT);
		push_random(40);
		write_capacity(3);
		push_random(40);

		wait_drained(20000);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			error_count++;
		end
		$display("Covered %0d input words and %0d result words over %0d capacity writes",
			words_taken, results_checked, cap_writes);
		$display("(capacities 0, 1, 2, 3, 7, 65, 4096 and 8191, with wrap, stalls and hold-off)");
		if (error_count == 0) begin
			$display("overwrite_trace_ring_buffer test passed");
		end else begin
			$display("overwrite_trace_ring_buffer test failed");
		end
		$finish;
	end

endmodule
